@@ rtl/lgcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lgcr_pkg
// Types and constants for the lease gated control register block.
// ----------------------------------------------------------------------------
package lgcr_pkg;

  // Item kinds
  localparam logic [1:0] ReqControl  = 2'd0;
  localparam logic [1:0] ReqLeaseEnd = 2'd1;
  localparam logic [1:0] ReqAcquire  = 2'd2;
  localparam logic [1:0] ReqCleanup  = 2'd3;

  // Control request header
  localparam logic [7:0] ReqLength  = 8'd6;
  localparam logic [7:0] HdrByte0   = 8'h44;  // 'D'
  localparam logic [7:0] HdrByte1   = 8'h4D;  // 'M'
  localparam logic [7:0] HdrVersion = 8'd1;

  // Opcodes
  localparam logic [7:0] OpTelemetry  = 8'd1;
  localparam logic [7:0] OpFlagsSet   = 8'd2;
  localparam logic [7:0] OpFlagsClear = 8'd3;
  localparam logic [7:0] OpCacheInfo  = 8'd4;
  localparam logic [7:0] OpCacheSize  = 8'd5;

  // Status codes
  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StMalformed   = 3'd1;
  localparam logic [2:0] StUnsupported = 3'd2;
  localparam logic [2:0] StNoLease     = 3'd3;
  localparam logic [2:0] StAllocated   = 3'd4;
  localparam logic [2:0] StOutOfBudget = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CfgFlagMask = 2'd0;
  localparam logic [1:0] CfgCacheMin = 2'd1;
  localparam logic [1:0] CfgCacheMax = 2'd2;

  localparam logic [15:0] FlagMaskReset = 16'h8007;
  localparam logic [9:0]  CacheMinReset = 10'd64;
  localparam logic [9:0]  CacheMaxReset = 10'd160;

  // Flag bit that asks to keep the cache across a lease end
  localparam int unsigned FlagCacheKeepBit = 1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] request_length;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] opcode_byte;
    logic [7:0] arg_low_byte;
    logic [7:0] arg_high_byte;
    logic       lease_held;
    logic       cache_allocated;
  } in_t;

  typedef struct packed {
    logic        reply_valid;
    logic [15:0] echo_tag;
    logic        crc_attach;
    logic [15:0] flags_now;
    logic [2:0]  status_now;
    logic [9:0]  cache_request_kib;
    logic        release_cache;
    logic        release_slots;
    logic        keep_latched_now;
  } out_t;

  typedef struct packed {
    logic [15:0] flags;
    logic [2:0]  status;
    logic [9:0]  cache_req;
    logic        settled;
    logic        keep;
  } regs_t;

  typedef struct packed {
    logic [15:0] flag_mask;
    logic [9:0]  cache_min;
    logic [9:0]  cache_max;
  } cfg_t;

endpackage

@@ rtl/lease_gated_control_registers_top.sv @@
// ----------------------------------------------------------------------------
// lease_gated_control_registers_top
// Control request decoder and lease event handler with gated flag and
// cache-size registers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        input      in_valid_i / in_ready_o     in_data_i  (lgcr_pkg::in_t)
//  out       output     out_valid_o / out_ready_i   out_data_o (lgcr_pkg::out_t)
//  cfg       input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
//  One transaction per cycle sustained while the output is not stalled; from input to result:
//  an input register, then decode and state update into the result register.
//  The state registers are updated as an item leaves the input register.
//  Reset clears the flags, status, size request, settled bit and keep latch,
//  and loads the configuration reset values. A stalled output holds both
//  stages; in_ready_o drops only when both stages are full and out is stalled.
// ----------------------------------------------------------------------------
module lease_gated_control_registers_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lgcr_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lgcr_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);
  import lgcr_pkg::*;

  logic  in_valid_q;
  in_t   in_q;
  logic  out_valid_q;
  out_t  out_q;
  regs_t regs_q;
  regs_t regs_d;
  cfg_t  cfg_q;
  out_t  res;
  logic  out_free;
  logic  advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  lgcr_exec u_exec (
    .item_i (in_q),
    .cur_i  (regs_q),
    .cfg_i  (cfg_q),
    .nxt_o  (regs_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '0;
      cfg_q       <= '{flag_mask: FlagMaskReset, cache_min: CacheMinReset,
                       cache_max: CacheMaxReset};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        regs_q <= regs_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFlagMask: cfg_q.flag_mask <= cfg_data_i;
          CfgCacheMin: cfg_q.cache_min <= cfg_data_i[9:0];
          CfgCacheMax: cfg_q.cache_max <= cfg_data_i[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // keep latch is only ever set while a lease is settled
  a_keep_needs_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.keep |-> regs_q.settled)
    else $error("keep latch set without settled lease");

  // slot release always comes with cleared flags and size request
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.release_slots) |->
      (out_q.flags_now == '0 && out_q.cache_request_kib == '0))
    else $error("slot release without cleared state");

  // no reply means no echoed id and no crc
  a_no_reply_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.reply_valid) |->
      (out_q.echo_tag == '0 && !out_q.crc_attach))
    else $error("echo tag or crc without reply");

  // a cleanup leaves the lease unsettled and the latch clear
  a_cleanup_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.req_type == ReqCleanup) |=> (!regs_q.settled && !regs_q.keep))
    else $error("cleanup did not clear lease state");

  // result register state matches the live registers after an update
  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_q.flags_now == regs_q.flags && out_q.status_now == regs_q.status))
    else $error("result does not match register state");
`endif

endmodule

@@ rtl/lgcr_exec.sv @@
// ----------------------------------------------------------------------------
// lgcr_exec
// Decodes one item against the current register state and returns the next
// state together with the result transaction.
// ----------------------------------------------------------------------------
module lgcr_exec (
  input  lgcr_pkg::in_t   item_i,
  input  lgcr_pkg::regs_t cur_i,
  input  lgcr_pkg::cfg_t  cfg_i,
  output lgcr_pkg::regs_t nxt_o,
  output lgcr_pkg::out_t  res_o
);
  import lgcr_pkg::*;

  logic [15:0] arg;
  logic        hdr_ok;
  logic        keep_bit;
  logic        size_bad;
  regs_t       nxt;
  out_t        res;

  assign arg      = {item_i.arg_high_byte, item_i.arg_low_byte};
  assign hdr_ok   = (item_i.request_length == ReqLength) && (item_i.byte_zero == HdrByte0) &&
                    (item_i.byte_one == HdrByte1) && (item_i.byte_two == HdrVersion);
  assign keep_bit = cur_i.flags[FlagCacheKeepBit];
  assign size_bad = (arg < {6'd0, cfg_i.cache_min}) || (arg > {6'd0, cfg_i.cache_max});

  always_comb begin
    nxt = cur_i;
    res = '0;
    case (item_i.req_type)
      ReqControl: begin
        if (!hdr_ok) begin
          nxt.status = StMalformed;
        end else begin
          res.reply_valid = 1'b1;
          case (item_i.opcode_byte)
            OpTelemetry: begin
              res.echo_tag = arg;
            end
            OpCacheInfo: begin
              res.echo_tag   = arg;
              res.crc_attach = 1'b1;
            end
            OpFlagsSet: begin
              if (!item_i.lease_held) begin
                nxt.status = StNoLease;
              end else if ((arg & ~cfg_i.flag_mask) != '0) begin
                nxt.status = StUnsupported;
              end else begin
                nxt.flags  = arg;
                nxt.status = StOk;
              end
            end
            OpFlagsClear: begin
              nxt.flags  = '0;
              nxt.status = StOk;
            end
            OpCacheSize: begin
              if (!item_i.lease_held) begin
                nxt.status = StNoLease;
              end else if (size_bad) begin
                nxt.status = StOutOfBudget;
              end else if (item_i.cache_allocated) begin
                nxt.status = StAllocated;
              end else begin
                nxt.cache_req = arg[9:0];
                nxt.status    = StOk;
              end
            end
            default: begin
              nxt.status = StMalformed;
            end
          endcase
        end
      end
      ReqLeaseEnd: begin
        nxt.flags = '0;
        if (!cur_i.settled) begin
          nxt.settled       = 1'b1;
          nxt.keep          = keep_bit;
          nxt.cache_req     = '0;
          res.release_cache = !keep_bit;
          res.release_slots = 1'b1;
        end
      end
      ReqAcquire: begin
        // an unsettled lease takes the release decision from the current keep flag bit
        res.release_cache = cur_i.settled ? !cur_i.keep : !keep_bit;
        res.release_slots = 1'b1;
        nxt.flags         = '0;
        nxt.cache_req     = '0;
        nxt.settled       = 1'b0;
        nxt.keep          = 1'b0;
      end
      default: begin
        res.release_cache = 1'b1;
        res.release_slots = 1'b1;
        nxt.flags         = '0;
        nxt.cache_req     = '0;
        nxt.settled       = 1'b0;
        nxt.keep          = 1'b0;
      end
    endcase
    res.flags_now         = nxt.flags;
    res.status_now        = nxt.status;
    res.cache_request_kib = nxt.cache_req;
    res.keep_latched_now  = nxt.keep;
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule
